FILE: sv/crsi_pkg.sv
// ---------------------------------------------------------------------------
// Catmull-Rom stroke interpolator package
// Shared types, constants and the output clamp for the stroke interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package crsi_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int CNT_W       = 7;
   localparam int CHAN_W      = 25;
   localparam int NUM_CHAN    = 8;
   localparam int DIV_W       = 23;
   localparam int WGT_W       = 20;
   localparam int ACC_W       = 48;
   localparam int REQ_DATA_W  = 144;
   localparam int RSP_DATA_W  = 168;
   localparam logic [15:0] PREC_RESET = 16'd256;

   localparam logic [2:0] CH_X     = 3'd0;
   localparam logic [2:0] CH_Y     = 3'd1;
   localparam logic [2:0] CH_PRESS = 3'd2;
   localparam logic [2:0] CH_TILTX = 3'd3;
   localparam logic [2:0] CH_TILTY = 3'd4;
   localparam logic [2:0] CH_WHEEL = 3'd5;
   localparam logic [2:0] CH_SPEED = 3'd6;
   localparam logic [2:0] CH_HEAD  = 3'd7;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] sample_type;
   typedef sample_type [3:0] points_type;

   typedef struct packed {
      points_type         pts;
      logic [CNT_W-1:0]   count;
      logic signed [16:0] delta;
   } seg_type;

   typedef enum logic [2:0] {
      F_IDLE, F_SQX, F_SQY, F_ROOT, F_DIV, F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_INIT, B_DIV, B_SQ, B_CUBE, B_WGT, B_MAC, B_EMIT
   } back_state_type;

   // Rounds a doubled-weight sum half up and saturates it to the channel range.
   function automatic logic [23:0] clamp_chan(input logic [2:0] k,
                                              input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] v;
      logic signed [ACC_W-1:0] lo;
      logic signed [ACC_W-1:0] hi;
      v = (acc + 48'sd65536) >>> 17;
      unique case (k)
         CH_X, CH_Y: begin
            lo = -48'sd8388608;
            hi = 48'sd8388607;
         end
         CH_TILTX, CH_TILTY: begin
            lo = -48'sd32768;
            hi = 48'sd32767;
         end
         default: begin
            lo = 48'sd0;
            hi = 48'sd65535;
         end
      endcase
      if (v < lo) begin
         return lo[23:0];
      end else if (v > hi) begin
         return hi[23:0];
      end
      return v[23:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/crsi_front.sv
// ---------------------------------------------------------------------------
// Stroke interpolator front end
// Keeps the sample window, measures the segment and issues segment jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module crsi_front import crsi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample,
   input  logic [15:0] prec,
   output logic       seg_valid,
   input  logic       seg_ready,
   output seg_type    seg
);

   front_state_type state_ff, state_in;
   sample_type [2:0] win_ff;
   logic [1:0]  held_ff;
   points_type  pts_ff, pts_in;
   logic [49:0] sq_ff, d_ff, r_ff, bit_ff;
   logic [25:0] rem_ff;
   logic [21:0] pd_ff;
   logic [5:0]  q_ff;
   logic        sat_ff;
   logic [2:0]  dstep_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic accept;
   logic [15:0] prec_eff;
   logic signed [25:0] dx, dy;
   logic signed [51:0] dx_sq, dy_sq;
   logic [49:0] root_sum, d_next, r_next;
   logic root_ge;
   logic div_ge, sat_now, sat_cur;
   logic [5:0] q_next;
   logic [CNT_W-1:0] raw_cnt;
   logic signed [17:0] hd;
   logic signed [17:0] hd_wrap;

   assign accept   = req_valid && req_ready;
   assign prec_eff = (prec == 16'd0) ? 16'd1 : prec;

   always_comb begin
      pts_in[0] = win_ff[0];
      pts_in[1] = win_ff[1];
      pts_in[2] = win_ff[2];
      pts_in[3] = req_sample;
   end

   assign dx = 26'($signed(pts_ff[2][CH_X])) - 26'($signed(pts_ff[1][CH_X]));
   assign dy = 26'($signed(pts_ff[2][CH_Y])) - 26'($signed(pts_ff[1][CH_Y]));
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   // One step of the bit-pair square root.
   assign root_sum = r_ff + bit_ff;
   assign root_ge  = d_ff >= root_sum;
   assign d_next   = root_ge ? d_ff - root_sum : d_ff;
   assign r_next   = root_ge ? (r_ff >> 1) + bit_ff : r_ff >> 1;

   // Restoring division of the distance by the spacing, six quotient bits.
   assign div_ge  = rem_ff >= {4'd0, pd_ff};
   assign q_next  = {q_ff[4:0], div_ge};
   assign sat_now = rem_ff >= {4'd0, prec_eff, 6'd0};
   assign sat_cur = (dstep_ff == 3'd0) ? sat_now : sat_ff;
   assign raw_cnt = sat_cur ? CNT_W'(64) : {1'b0, q_next};
   assign cnt_in  = (raw_cnt > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : raw_cnt;

   // Heading change taken the short way around.
   assign hd = 18'($signed({2'b00, pts_ff[2][CH_HEAD][15:0]}))
             - 18'($signed({2'b00, pts_ff[1][CH_HEAD][15:0]}));
   always_comb begin
      if (hd <= -18'sd32768) begin
         hd_wrap = hd + 18'sd65536;
      end else if (hd >= 18'sd32768) begin
         hd_wrap = hd - 18'sd65536;
      end else begin
         hd_wrap = hd;
      end
   end

   always_comb begin
      seg.pts   = pts_ff;
      seg.count = cnt_ff;
      seg.delta = hd_wrap[16:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && held_ff == 2'd3) state_in = F_SQX;
         end
         F_SQX:  state_in = F_SQY;
         F_SQY:  state_in = F_ROOT;
         F_ROOT: begin
            if (bit_ff[0]) state_in = F_DIV;
         end
         F_DIV: begin
            if (dstep_ff == 3'd5) state_in = (cnt_in != '0) ? F_PUSH : F_IDLE;
         end
         F_PUSH: begin
            if (seg_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == F_IDLE);
      seg_valid = (state_ff == F_PUSH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         held_ff  <= 2'd0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= req_sample;
            if (held_ff != 2'd3) held_ff <= held_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         F_IDLE: begin
            if (accept) pts_ff <= pts_in;
         end
         F_SQX: sq_ff <= 50'(dx_sq);
         F_SQY: begin
            d_ff   <= sq_ff + 50'(dy_sq);
            r_ff   <= '0;
            bit_ff <= 50'd1 << 48;
         end
         F_ROOT: begin
            d_ff     <= d_next;
            r_ff     <= r_next;
            bit_ff   <= bit_ff >> 2;
            rem_ff   <= r_next[25:0];
            pd_ff    <= {1'b0, prec_eff, 5'd0};
            dstep_ff <= 3'd0;
         end
         F_DIV: begin
            if (div_ge) rem_ff <= rem_ff - {4'd0, pd_ff};
            pd_ff    <= pd_ff >> 1;
            q_ff     <= q_next;
            sat_ff   <= sat_cur;
            dstep_ff <= dstep_ff + 3'd1;
            cnt_ff   <= cnt_in;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/crsi_queue.sv
// ---------------------------------------------------------------------------
// Stroke interpolator segment queue
// Two-entry queue of segment jobs between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module crsi_queue import crsi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  seg_type push_seg,
   output logic    pop_valid,
   input  logic    pop_ready,
   output seg_type pop_seg
);

   seg_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_seg    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_seg;
   end

endmodule

`default_nettype wire

FILE: sv/crsi_back.sv
// ---------------------------------------------------------------------------
// Stroke interpolator back end
// Walks the points of one segment and evaluates the spline for each.
// ---------------------------------------------------------------------------
`default_nettype none

module crsi_back import crsi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    seg_valid,
   output logic    seg_ready,
   input  seg_type seg,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output logic [RSP_DATA_W-1:0] rsp_data,
   output logic    rsp_last
);

   back_state_type state_ff, state_in;
   seg_type        seg_ff;
   logic [CNT_W-1:0] n_ff;
   logic [DIV_W-1:0] nqt_ff, nqh_ff;
   logic [CNT_W:0]   remt_ff, remh_ff;
   logic [4:0]       step_ff;
   logic             neg_ff;
   logic [16:0]      t_ff, t2_ff, t3_ff;
   logic [3:0][WGT_W-1:0] w_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [2:0]       k_ff;
   logic [1:0]       j_ff;
   logic [6:0][23:0] res_ff;
   logic [15:0]      head_ff;
   logic             out_valid_ff, out_last_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic out_free, is_last;
   logic signed [24:0] hprod;
   logic [CNT_W:0] rt_sh, rh_sh;
   logic gt, gh;
   logic [33:0] t_sq, t_cube;
   logic [15:0] hq;
   logic signed [WGT_W-1:0] ts, t2s, t3s;
   logic signed [44:0] mac_prod;

   assign out_free = !out_valid_ff || rsp_ready;
   assign is_last  = (n_ff == seg_ff.count);

   assign hprod = $signed(seg_ff.delta) * $signed({1'b0, n_ff});

   // Two restoring dividers share the step counter: parameter and heading step.
   assign rt_sh = {remt_ff[CNT_W-1:0], nqt_ff[DIV_W-1]};
   assign rh_sh = {remh_ff[CNT_W-1:0], nqh_ff[DIV_W-1]};
   assign gt    = rt_sh >= {1'b0, seg_ff.count};
   assign gh    = rh_sh >= {1'b0, seg_ff.count};

   assign t_sq   = nqt_ff[16:0] * nqt_ff[16:0];
   assign t_cube = t2_ff * t_ff;

   // Floor division of a negative heading step rounds away from zero.
   assign hq = neg_ff ? 16'(-(nqh_ff[15:0] + {15'd0, remh_ff != '0})) : nqh_ff[15:0];

   assign ts  = WGT_W'(t_ff);
   assign t2s = WGT_W'(t2_ff);
   assign t3s = WGT_W'(t3_ff);

   assign mac_prod = $signed(w_ff[j_ff]) * $signed(seg_ff.pts[j_ff][k_ff]);
   assign acc_in   = ((j_ff == 2'd0) ? '0 : acc_ff) + ACC_W'(mac_prod);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (seg_valid) state_in = B_INIT;
         end
         B_INIT: state_in = B_DIV;
         B_DIV: begin
            if (step_ff == 5'(DIV_W - 1)) state_in = B_SQ;
         end
         B_SQ:   state_in = B_CUBE;
         B_CUBE: state_in = B_WGT;
         B_WGT:  state_in = B_MAC;
         B_MAC: begin
            if (k_ff == 3'd6 && j_ff == 2'd3) state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) state_in = is_last ? B_IDLE : B_INIT;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      seg_ready = (state_ff == B_IDLE);
      rsp_valid = out_valid_ff;
      rsp_data  = out_data_ff;
      rsp_last  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_EMIT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            if (seg_valid) begin
               seg_ff <= seg;
               n_ff   <= CNT_W'(1);
            end
         end
         B_INIT: begin
            nqt_ff  <= {n_ff, 16'd0};
            nqh_ff  <= hprod[24] ? DIV_W'(-hprod) : DIV_W'(hprod);
            neg_ff  <= hprod[24];
            remt_ff <= '0;
            remh_ff <= '0;
            step_ff <= 5'd0;
         end
         B_DIV: begin
            remt_ff <= gt ? rt_sh - {1'b0, seg_ff.count} : rt_sh;
            remh_ff <= gh ? rh_sh - {1'b0, seg_ff.count} : rh_sh;
            nqt_ff  <= {nqt_ff[DIV_W-2:0], gt};
            nqh_ff  <= {nqh_ff[DIV_W-2:0], gh};
            step_ff <= step_ff + 5'd1;
         end
         B_SQ: begin
            t_ff    <= nqt_ff[16:0];
            t2_ff   <= t_sq[32:16];
            head_ff <= seg_ff.pts[1][CH_HEAD][15:0] + hq;
         end
         B_CUBE: t3_ff <= t_cube[32:16];
         B_WGT: begin
            w_ff[0] <= WGT_W'(-t3s + (t2s <<< 1) - ts);
            w_ff[1] <= WGT_W'(3 * t3s - 5 * t2s + 20'sd131072);
            w_ff[2] <= WGT_W'(-3 * t3s + (t2s <<< 2) + ts);
            w_ff[3] <= WGT_W'(t3s - t2s);
            k_ff    <= 3'd0;
            j_ff    <= 2'd0;
         end
         B_MAC: begin
            acc_ff <= acc_in;
            j_ff   <= j_ff + 2'd1;
            if (j_ff == 2'd3) begin
               res_ff[k_ff] <= clamp_chan(k_ff, acc_in);
               k_ff         <= k_ff + 3'd1;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               out_data_ff <= {7'd0, t_ff, head_ff, res_ff[6][15:0], res_ff[5][15:0],
                               res_ff[4][15:0], res_ff[3][15:0], res_ff[2][15:0],
                               res_ff[1], res_ff[0]};
               out_last_ff <= is_last;
               n_ff        <= n_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/catmull_rom_stroke_interpolator.sv
// ---------------------------------------------------------------------------
// Catmull-Rom stroke interpolator
// Turns pen samples into evenly spaced spline points between the two middle
// samples of a four-sample window.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   req_      in         one pen sample (position, pressure, tilts, wheel,
//                        speed, heading)
//   rsp_      out        one interpolated point, tlast on the final point
//   csr_      in         point spacing register, write only
//
// The front end takes a beat only while idle. With a full window it then
// works out the segment length (squaring x and y, a 25-step square root and
// a 6-step division) and hands the job to a two-entry queue, waiting while
// the queue is full; a segment with no points skips the hand-over.
// The back end picks up a job and then, for each point, runs a setup step, a
// 23-step divider pair for the parameter and heading step, squaring, cubing
// and weight steps, one pass per weight through a single multiply-accumulate
// unit for each of the seven channels, and a load of the output register,
// which waits while the result consumer stalls.
// Reset is synchronous and empties the window, queue and output register;
// the spacing register returns to 256. Either side may stall freely: the
// queue and the output register decouple the input, the arithmetic and the
// result consumer.
`default_nettype none

module catmull_rom_stroke_interpolator import crsi_pkg::*; (
   input  logic clock,
   input  logic reset,
   // pos_x[23:0], pos_y[47:24], pressure_in[63:48], tilt_x_in[79:64],
   // tilt_y_in[95:80], wheel_in[111:96], speed_in[127:112], heading_in[143:128]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // out_x[23:0], out_y[47:24], out_pressure[63:48], out_tilt_x[79:64],
   // out_tilt_y[95:80], out_wheel[111:96], out_speed[127:112],
   // out_heading[143:128], param[160:144], zero fill[167:161]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic rsp_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0] prec_ff;
   sample_type  req_sample;
   logic        seg_push_valid, seg_push_ready, seg_pop_valid, seg_pop_ready;
   seg_type     seg_push, seg_pop;

   // Spacing register, in 1/256 pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff <= PREC_RESET;
      end else if (csr_we) begin
         prec_ff <= csr_wdata;
      end
   end

   // Every channel is widened to one signed format for the spline math.
   always_comb begin
      req_sample[CH_X]     = CHAN_W'($signed(req_tdata[23:0]));
      req_sample[CH_Y]     = CHAN_W'($signed(req_tdata[47:24]));
      req_sample[CH_PRESS] = {9'd0, req_tdata[63:48]};
      req_sample[CH_TILTX] = CHAN_W'($signed(req_tdata[79:64]));
      req_sample[CH_TILTY] = CHAN_W'($signed(req_tdata[95:80]));
      req_sample[CH_WHEEL] = {9'd0, req_tdata[111:96]};
      req_sample[CH_SPEED] = {9'd0, req_tdata[127:112]};
      req_sample[CH_HEAD]  = {9'd0, req_tdata[143:128]};
   end

   crsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_sample (req_sample),
      .prec       (prec_ff),
      .seg_valid  (seg_push_valid),
      .seg_ready  (seg_push_ready),
      .seg        (seg_push)
   );

   crsi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (seg_push_valid),
      .push_ready (seg_push_ready),
      .push_seg   (seg_push),
      .pop_valid  (seg_pop_valid),
      .pop_ready  (seg_pop_ready),
      .pop_seg    (seg_pop)
   );

   crsi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seg_valid  (seg_pop_valid),
      .seg_ready  (seg_pop_ready),
      .seg        (seg_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: sv/crsi_checker.sv
// ---------------------------------------------------------------------------
// Stroke interpolator port checker
// Watches the top-level ports and flags broken output and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none

module crsi_checker import crsi_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic rsp_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // The final point of a run is exactly the one at parameter one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[160:144] == 17'h10000)))
      else $error("last flag disagrees with parameter");

   // Reset leaves no result pending and the input open.
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

   // The parameter never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[160] == 1'b0 || rsp_tdata[159:144] == 16'd0))
      else $error("parameter out of range");

endmodule

bind catmull_rom_stroke_interpolator crsi_checker u_crsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
